// ===== rtl/tdxq_pkg.sv =====
// tdxq_pkg: result types and status codes for the quote certification chain locator
// used by tdxq_res_buf and tdx_quote_cert_chain_locator_unit; no dependencies
`default_nettype none

package tdxq_pkg;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_TEE     = 3'd2,
    ST_VERSION = 3'd3,
    ST_STRUCT  = 3'd4,
    ST_OVER    = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] quote_version;
    logic [15:0] sig_data_offset;
    logic [15:0] sig_data_length;
    logic [15:0] chain_offset;
    logic [15:0] chain_length;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/tdxq_res_buf.sv =====
// tdxq_res_buf: two-entry result buffer (output register plus skid register)
// depends on tdxq_pkg for result_t
`default_nettype none

module tdxq_res_buf
  import tdxq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  input  wire logic    pop_ready,
  output logic         out_valid,
  output result_t      out_data
);

  logic    sk_valid;
  result_t sk_data;
  logic    pop;

  assign pop  = out_valid && pop_ready;
  assign full = sk_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (pop) begin
      if (sk_valid) begin
        sk_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        sk_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (sk_valid) begin
        out_data <= sk_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data <= push_data;
      end else begin
        sk_data <= push_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> out_valid)
    else $error("skid entry held without output entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && sk_valid))
    else $error("result pushed into full buffer");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !out_valid) |=> out_valid)
    else $error("pushed result not presented");

endmodule

`default_nettype wire

// ===== rtl/tdx_quote_cert_chain_locator_unit.sv =====
// tdx_quote_cert_chain_locator_unit: byte-serial quote parser, one byte per cycle
// result: a quote's result is pushed into the result buffer on its tlast transfer and is registered before m_tvalid
// throughput: one byte per cycle; a two-entry result buffer keeps input flowing
// while a result waits, so s_tready drops only when both entries are occupied
// reset: synchronous rst clears parser state and empties the result buffer
// depends on tdxq_pkg and tdxq_res_buf
`default_nettype none

module tdx_quote_cert_chain_locator_unit
  import tdxq_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata    // status[2:0], quote_version[18:3],
                                      // sig_data_offset[34:19], sig_data_length[50:35],
                                      // chain_offset[66:51], chain_length[82:67], zero
);

  localparam int BW = POSITION_BITS + 1;
  localparam int PW = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 2;

  localparam logic [31:0] TEE_TDX     = 32'h0000_0081;
  localparam int unsigned HDR_LEN     = 48;
  localparam int unsigned V4_BODY     = 584;
  localparam int unsigned SIGKEY_LEN  = 128;
  localparam int unsigned CERT_HDR    = 6;
  localparam int unsigned QE_SKIP     = 384 + 64;
  localparam logic [15:0] TYPE_QE     = 16'd6;
  localparam logic [15:0] TYPE_PCK    = 16'd5;
  localparam logic [15:0] VER_4       = 16'd4;
  localparam logic [15:0] VER_5       = 16'd5;
  localparam int unsigned BODY_SZ_POS = HDR_LEN + 2;
  localparam int unsigned HDR_END_POS = BODY_SZ_POS + 3;

  typedef enum logic [8:0] {
    PH_HDR    = 9'b000000001,
    PH_SIGLEN = 9'b000000010,
    PH_OTYPE  = 9'b000000100,
    PH_OSIZE  = 9'b000001000,
    PH_AUTH   = 9'b000010000,
    PH_ITYPE  = 9'b000100000,
    PH_ISIZE  = 9'b001000000,
    PH_DONE   = 9'b010000000,
    PH_IDLE   = 9'b100000000
  } phase_t;

  function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] lane, logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (lane)
      2'd0:    r[7:0]   = w[7:0]   | b;
      2'd1:    r[15:8]  = w[15:8]  | b;
      2'd2:    r[23:16] = w[23:16] | b;
      2'd3:    r[31:24] = w[31:24] | b;
      default: r = w;
    endcase
    return r;
  endfunction

  logic [BW-1:0] bp, bp_next;
  logic [31:0]   fa, fa_next;
  phase_t        phase, phase_next;
  logic [PW-1:0] nfp, nfp_next;
  logic [15:0]   hver, hver_next;
  logic [31:0]   htee, htee_next;
  logic [PW-1:0] ss, ss_next;
  logic [31:0]   slen, slen_next;
  logic [PW-1:0] oend, oend_next;
  logic [31:0]   isize, isize_next;
  logic          fault, fault_next;

  logic          accept;
  logic          over;
  logic [PW-1:0] pos;
  logic [PW-1:0] diff;
  logic          field_ph;
  logic          wide_field;
  logic          in_field;
  logic [1:0]    k;
  logic [1:0]    klast;
  logic          fdone;
  logic [31:0]   asm_v;
  logic [31:0]   hdr_fa;
  logic [1:0]    hdr_lane;
  logic [PW-1:0] len;
  status_t       status;
  result_t       res;
  result_t       out_res;
  logic          buf_full;

  assign accept = s_tvalid && s_tready;
  assign s_tready = !buf_full;
  assign over = bp[BW-1];

  always_comb begin
    pos        = PW'(bp);
    diff       = pos - nfp;
    wide_field = (phase == PH_SIGLEN) || (phase == PH_OSIZE) || (phase == PH_ISIZE);
    field_ph   = !((phase == PH_HDR) || (phase == PH_DONE) || (phase == PH_IDLE));
    in_field   = field_ph && (pos >= nfp) && (diff < (wide_field ? PW'(4) : PW'(2)));
    k          = diff[1:0];
    klast      = wide_field ? 2'd3 : 2'd1;
    fdone      = in_field && (k == klast);
    asm_v      = put_byte(fa, k, s_tdata);
    hdr_lane   = 2'(bp - BW'(BODY_SZ_POS));
    hdr_fa     = put_byte(fa, hdr_lane, s_tdata);

    bp_next    = bp;
    fa_next    = fa;
    phase_next = phase;
    nfp_next   = nfp;
    hver_next  = hver;
    htee_next  = htee;
    ss_next    = ss;
    slen_next  = slen;
    oend_next  = oend;
    isize_next = isize;
    fault_next = fault;

    if (over) begin
      bp_next = {1'b1, (BW-1)'(1)};
    end else begin
      bp_next = bp + BW'(1);
      if (in_field) begin
        fa_next = fdone ? 32'd0 : asm_v;
      end
      case (phase)
        PH_HDR: begin
          if (bp < BW'(2)) begin
            hver_next = bp[0] ? (hver | {s_tdata, 8'd0}) : (hver | {8'd0, s_tdata});
          end
          if ((bp >= BW'(4)) && (bp < BW'(8))) begin
            htee_next = put_byte(htee, bp[1:0], s_tdata);
          end
          if ((bp >= BW'(BODY_SZ_POS)) && (bp <= BW'(HDR_END_POS))) begin
            fa_next = hdr_fa;
          end
          if (bp == BW'(HDR_END_POS)) begin
            fa_next = 32'd0;
            if (hver == VER_4) begin
              nfp_next   = PW'(HDR_LEN + V4_BODY);
              phase_next = PH_SIGLEN;
            end else if (hver == VER_5) begin
              nfp_next   = PW'(HDR_LEN + CERT_HDR) + PW'(hdr_fa);
              phase_next = PH_SIGLEN;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        PH_SIGLEN: begin
          if (fdone) begin
            slen_next = asm_v;
            ss_next   = nfp + PW'(4);
            oend_next = nfp + PW'(4) + PW'(asm_v);
            nfp_next  = nfp + PW'(4 + SIGKEY_LEN);
            if (asm_v < 32'(SIGKEY_LEN + CERT_HDR)) begin
              fault_next = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_OTYPE;
            end
          end
        end
        PH_OTYPE: begin
          if (fdone) begin
            if (asm_v[15:0] != TYPE_QE) begin
              fault_next = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              nfp_next   = nfp + PW'(2);
              phase_next = PH_OSIZE;
            end
          end
        end
        PH_OSIZE: begin
          if (fdone) begin
            if ((nfp + PW'(4) + PW'(asm_v) != oend) || (asm_v < 32'(QE_SKIP + 2))) begin
              fault_next = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              nfp_next   = nfp + PW'(4 + QE_SKIP);
              phase_next = PH_AUTH;
            end
          end
        end
        PH_AUTH: begin
          if (fdone) begin
            if (nfp + PW'(asm_v[15:0]) + PW'(2 + CERT_HDR) > oend) begin
              fault_next = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              nfp_next   = nfp + PW'(2) + PW'(asm_v[15:0]);
              phase_next = PH_ITYPE;
            end
          end
        end
        PH_ITYPE: begin
          if (fdone) begin
            if (asm_v[15:0] != TYPE_PCK) begin
              fault_next = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              nfp_next   = nfp + PW'(2);
              phase_next = PH_ISIZE;
            end
          end
        end
        PH_ISIZE: begin
          if (fdone) begin
            if (nfp + PW'(4) + PW'(asm_v) != oend) begin
              fault_next = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              isize_next = asm_v;
              nfp_next   = nfp + PW'(4);
              phase_next = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // end of block only moves on a signature length field, which never ends in DONE
  always_comb begin
    len = PW'(bp) + PW'(1);
    if (over) begin
      status = ST_OVER;
    end else if (bp < BW'(HDR_LEN - 1)) begin
      status = ST_SHORT;
    end else if (htee != TEE_TDX) begin
      status = ST_TEE;
    end else if ((hver_next != VER_4) && (hver_next != VER_5)) begin
      status = ST_VERSION;
    end else if ((phase_next == PH_HDR) || (phase_next == PH_SIGLEN)) begin
      status = ST_SHORT;
    end else if (fault_next || (oend > len) || (phase_next != PH_DONE)) begin
      status = ST_STRUCT;
    end else begin
      status = ST_OK;
    end

    res.status          = status;
    res.quote_version   = hver_next;
    res.sig_data_offset = ((status == ST_OK) || (status == ST_STRUCT)) ? ss_next[15:0] : 16'd0;
    res.sig_data_length = (status == ST_OK) ? slen_next[15:0] : 16'd0;
    res.chain_offset    = (status == ST_OK) ? nfp_next[15:0] : 16'd0;
    res.chain_length    = (status == ST_OK) ? isize_next[15:0] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      bp    <= '0;
      fa    <= '0;
      phase <= PH_HDR;
      nfp   <= '0;
      hver  <= '0;
      htee  <= '0;
      ss    <= '0;
      slen  <= '0;
      oend  <= '0;
      isize <= '0;
      fault <= 1'b0;
    end else if (accept) begin
      bp    <= bp_next;
      fa    <= fa_next;
      phase <= phase_next;
      nfp   <= nfp_next;
      hver  <= hver_next;
      htee  <= htee_next;
      ss    <= ss_next;
      slen  <= slen_next;
      oend  <= oend_next;
      isize <= isize_next;
      fault <= fault_next;
    end
  end

  tdxq_res_buf u_res_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && s_tlast),
    .push_data (res),
    .full      (buf_full),
    .pop_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (out_res)
  );

  assign m_tdata = {5'd0,
                    out_res.chain_length,
                    out_res.chain_offset,
                    out_res.sig_data_length,
                    out_res.sig_data_offset,
                    out_res.quote_version,
                    out_res.status};

  a_fault_stops: assert property (@(posedge clk) disable iff (rst)
    fault |-> (phase == PH_IDLE))
    else $error("structure fault without parser stop");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> ((bp == '0) && (phase == PH_HDR) && !fault))
    else $error("parser not restarted after final byte");

  a_header_consumed: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HDR) |-> (bp > BW'(HDR_END_POS)))
    else $error("parser left header phase early");

  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result buffer");

endmodule

`default_nettype wire
